FILE: rtl/core/fmnp_pkg.sv
// Shared constants, codes and helpers for the frame max-normalize pack block.
package fmnp_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int OPCODE_BITS    = 2;
    localparam int COORD_BITS     = 8;
    localparam int IN_SAMPLE_BITS = 16;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_IDX_BITS   = 2;
    localparam int LIM_BITS       = 13;
    localparam int COMP_BITS      = 8;
    localparam int PIXEL_BITS     = 32;
    localparam int NUM_CHANNELS   = 3;
    localparam int CH_BITS        = 2;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS_PER_CYCLE = 2;

    localparam logic [CFG_DATA_BITS-1:0] ACTIVE_RESET = 9'd256;
    localparam logic [COMP_BITS-1:0]     ALPHA_OPAQUE = 8'hFF;
    localparam logic [COMP_BITS-1:0]     COMP_FULL    = 8'hFF;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_WRITE   = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_READ    = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ACTIVE_WIDTH  = 2'd0,
        REG_ACTIVE_HEIGHT = 2'd1,
        REG_BIG_ENDIAN    = 2'd2
    } t_cfg_reg;

    function automatic logic [PIXEL_BITS-1:0] pack_pixel(
        input logic                 big,
        input logic [COMP_BITS-1:0] red,
        input logic [COMP_BITS-1:0] green,
        input logic [COMP_BITS-1:0] blue
    );
        logic [PIXEL_BITS-1:0] word;
        if (big) begin
            word = {red, green, blue, ALPHA_OPAQUE};
        end else begin
            word = {ALPHA_OPAQUE, blue, green, red};
        end
        return word;
    endfunction

endpackage

FILE: rtl/core/fmnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fmnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/fmnp_div.sv
// Iterative restoring divider: floor(sample*255/divisor), DIV_STEPS_PER_CYCLE quotient bits per cycle.
module fmnp_div #(
    parameter int SAMPLE_BITS = fmnp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic [SAMPLE_BITS-1:0]         i_divisor,
    output logic                           o_done,
    output logic [fmnp_pkg::COMP_BITS-1:0] o_quot
);
    import fmnp_pkg::*;

    localparam int NUM_BITS = SAMPLE_BITS + COMP_BITS;
    localparam int ITERS    = COMP_BITS / DIV_STEPS_PER_CYCLE;
    localparam int CNT_BITS = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [COMP_BITS-1:0]   r_low;
    logic [SAMPLE_BITS-1:0] r_div;
    logic [COMP_BITS-1:0]   r_quot;

    logic [NUM_BITS-1:0]    num;
    logic [SAMPLE_BITS-1:0] n_rem;
    logic [COMP_BITS-1:0]   n_low;
    logic [COMP_BITS-1:0]   n_quot;

    // sample*255 as (sample << 8) - sample
    assign num = {i_sample, {COMP_BITS{1'b0}}} - {{COMP_BITS{1'b0}}, i_sample};

    always_comb begin
        logic [SAMPLE_BITS:0] trial;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        trial  = '0;
        for (int k = 0; k < DIV_STEPS_PER_CYCLE; k++) begin
            trial = {n_rem, n_low[COMP_BITS-1]};
            n_low = {n_low[COMP_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem  = SAMPLE_BITS'(trial - {1'b0, r_div});
                n_quot = {n_quot[COMP_BITS-2:0], 1'b1};
            end else begin
                n_rem  = trial[SAMPLE_BITS-1:0];
                n_quot = {n_quot[COMP_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= num[NUM_BITS-1:COMP_BITS];
                r_low  <= num[COMP_BITS-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_low  <= n_low;
                r_quot <= n_quot;
                r_cnt  <= CNT_BITS'(r_cnt + 1'b1);
                if (r_cnt == CNT_BITS'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/frame_max_normalize_pack.sv
// Top level: frame store with peak scan and max-normalized RGBA8888 readout.
// Reset (i_rst_n low, synchronous) clears control state, then a clearing pass writes zero
// to all MAX_WIDTH*MAX_HEIGHT store entries, one a cycle; busy holds.
// Write: no result. Compute: scans the active width*height area, one store read a cycle.
// Read in area: three passes of the shared divider (2 quotient bits/cycle), one per channel;
// strobe after the third pass. Read out of area: strobe the next cycle.
// Results show for exactly one cycle on o_strobe; the receiver cannot stall.
module frame_max_normalize_pack #(
    parameter int MAX_WIDTH   = fmnp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = fmnp_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = fmnp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [fmnp_pkg::OPCODE_BITS-1:0]    i_opcode,
    input  logic [fmnp_pkg::COORD_BITS-1:0]     i_col,
    input  logic [fmnp_pkg::COORD_BITS-1:0]     i_row,
    input  logic [fmnp_pkg::IN_SAMPLE_BITS-1:0] i_red_in,
    input  logic [fmnp_pkg::IN_SAMPLE_BITS-1:0] i_green_in,
    input  logic [fmnp_pkg::IN_SAMPLE_BITS-1:0] i_blue_in,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [fmnp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [fmnp_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // result channel
    output logic                                o_strobe,
    output logic [fmnp_pkg::PIXEL_BITS-1:0]     o_packed_pixel,
    output logic                                o_in_area
);
    import fmnp_pkg::*;

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIX_BITS  = NUM_CHANNELS * SAMPLE_BITS;
    localparam logic [LIM_BITS-1:0] MAX_W_LIM = LIM_BITS'(MAX_WIDTH);
    localparam logic [LIM_BITS-1:0] MAX_H_LIM = LIM_BITS'(MAX_HEIGHT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RDWAIT,
        S_DIV
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                    r_state,     n_state;
    logic [AW-1:0]             r_clr_addr,  n_clr_addr;
    logic [CFG_DATA_BITS-1:0]  r_act_w,     n_act_w;
    logic [CFG_DATA_BITS-1:0]  r_act_h,     n_act_h;
    logic                      r_big,       n_big;
    logic [CFG_DATA_BITS-1:0]  r_x,         n_x;
    logic [CFG_DATA_BITS-1:0]  r_y,         n_y;
    logic [AW-1:0]             r_scan_addr, n_scan_addr;
    logic [AW-1:0]             r_row_base,  n_row_base;
    logic                      r_rd_vld,    n_rd_vld;
    logic [SAMPLE_BITS-1:0]    r_run,       n_run;
    logic [SAMPLE_BITS-1:0]    r_peak,      n_peak;
    logic [PIX_BITS-1:0]       r_pix,       n_pix;
    logic [CH_BITS-1:0]        r_ch,        n_ch;
    logic [COMP_BITS-1:0]      r_comp [NUM_CHANNELS];
    logic [COMP_BITS-1:0]      n_comp [NUM_CHANNELS];
    logic                      r_strobe,    n_strobe;
    logic [PIXEL_BITS-1:0]     r_packed,    n_packed;
    logic                      r_in_area,   n_in_area;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [LIM_BITS-1:0]      lim_w, lim_h;
    logic [CFG_DATA_BITS-1:0] eff_w, eff_h;
    logic                     coord_in_area;
    logic [AW-1:0]            req_addr;
    logic                     accept;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [PIX_BITS-1:0]      ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [PIX_BITS-1:0]      ram_rdata;
    logic                     div_start;
    logic [SAMPLE_BITS-1:0]   div_sample;
    logic                     div_done;
    logic [COMP_BITS-1:0]     div_quot;
    logic [SAMPLE_BITS-1:0]   rd_max3;
    logic [SAMPLE_BITS-1:0]   run_max;
    logic [SAMPLE_BITS-1:0]   cur_sample;
    logic [COMP_BITS-1:0]     cur_comp;

    function automatic logic [SAMPLE_BITS-1:0] chan_sel(
        input logic [PIX_BITS-1:0] pix,
        input logic [CH_BITS-1:0]  ch
    );
        logic [SAMPLE_BITS-1:0] s;
        case (ch)
            CH_BITS'(0): s = pix[0*SAMPLE_BITS +: SAMPLE_BITS];
            CH_BITS'(1): s = pix[1*SAMPLE_BITS +: SAMPLE_BITS];
            CH_BITS'(2): s = pix[2*SAMPLE_BITS +: SAMPLE_BITS];
            default:     s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] max2(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // Clamp the size registers to the store geometry; the result always fits 9 bits.
    assign lim_w = ({{(LIM_BITS-CFG_DATA_BITS){1'b0}}, r_act_w} < MAX_W_LIM)
                 ? {{(LIM_BITS-CFG_DATA_BITS){1'b0}}, r_act_w} : MAX_W_LIM;
    assign lim_h = ({{(LIM_BITS-CFG_DATA_BITS){1'b0}}, r_act_h} < MAX_H_LIM)
                 ? {{(LIM_BITS-CFG_DATA_BITS){1'b0}}, r_act_h} : MAX_H_LIM;
    assign eff_w = lim_w[CFG_DATA_BITS-1:0];
    assign eff_h = lim_h[CFG_DATA_BITS-1:0];

    assign coord_in_area = ({1'b0, i_col} < eff_w) && ({1'b0, i_row} < eff_h);
    assign req_addr      = AW'(32'(i_row) * 32'(MAX_WIDTH) + 32'(i_col));
    assign accept        = start && !busy;

    // Peak of the word just read, then merged with the running peak.
    assign rd_max3 = max2(max2(chan_sel(ram_rdata, CH_BITS'(0)),
                               chan_sel(ram_rdata, CH_BITS'(1))),
                          chan_sel(ram_rdata, CH_BITS'(2)));
    assign run_max = max2(r_run, rd_max3);

    // Zero peak gives zero; a sample above the peak saturates.
    assign cur_sample = chan_sel(r_pix, r_ch);
    assign cur_comp   = (r_peak == '0)         ? '0        :
                        (cur_sample > r_peak)  ? COMP_FULL : div_quot;

    // Store write port: zero fill during the clearing pass, else pixel writes.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = req_addr;
        ram_wdata = {SAMPLE_BITS'(i_blue_in), SAMPLE_BITS'(i_green_in), SAMPLE_BITS'(i_red_in)};
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (accept && (i_opcode == OP_WRITE) && coord_in_area) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = (r_state == S_SCAN) ? r_scan_addr : req_addr;

    // Divider: first channel straight from the store, the others back to back from r_pix.
    assign div_start  = (r_state == S_RDWAIT) ||
                        ((r_state == S_DIV) && div_done && (r_ch != CH_BITS'(NUM_CHANNELS - 1)));
    assign div_sample = (r_state == S_RDWAIT) ? chan_sel(ram_rdata, CH_BITS'(0))
                                              : chan_sel(r_pix, CH_BITS'(r_ch + 1'b1));

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_act_w     = r_act_w;
        n_act_h     = r_act_h;
        n_big       = r_big;
        n_x         = r_x;
        n_y         = r_y;
        n_scan_addr = r_scan_addr;
        n_row_base  = r_row_base;
        n_rd_vld    = 1'b0;
        n_run       = r_run;
        n_peak      = r_peak;
        n_pix       = r_pix;
        n_ch        = r_ch;
        n_comp      = r_comp;
        n_strobe    = 1'b0;
        n_packed    = r_packed;
        n_in_area   = r_in_area;

        // Configuration is taken in every state.
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ACTIVE_WIDTH:  n_act_w = i_cfg_wdata;
                REG_ACTIVE_HEIGHT: n_act_h = i_cfg_wdata;
                REG_BIG_ENDIAN:    n_big   = i_cfg_wdata[0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = AW'(r_clr_addr + 1'b1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    case (t_opcode'(i_opcode))
                        OP_WRITE: ; // store port handles it
                        OP_COMPUTE: begin
                            if ((eff_w == '0) || (eff_h == '0)) begin
                                n_peak = '0;
                            end else begin
                                n_state     = S_SCAN;
                                n_x         = '0;
                                n_y         = '0;
                                n_scan_addr = '0;
                                n_row_base  = '0;
                                n_run       = '0;
                            end
                        end
                        OP_READ: begin
                            if (coord_in_area) begin
                                n_state = S_RDWAIT;
                            end else begin
                                n_strobe  = 1'b1;
                                n_packed  = '0;
                                n_in_area = 1'b0;
                            end
                        end
                        default: ; // drop the unused code
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one store read a cycle, merge the word read last cycle.
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    n_run = run_max;
                end
                if (r_x == CFG_DATA_BITS'(eff_w - 1'b1)) begin
                    n_x         = '0;
                    n_y         = CFG_DATA_BITS'(r_y + 1'b1);
                    n_row_base  = AW'(r_row_base + AW'(MAX_WIDTH));
                    n_scan_addr = AW'(r_row_base + AW'(MAX_WIDTH));
                    if (r_y == CFG_DATA_BITS'(eff_h - 1'b1)) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_x         = CFG_DATA_BITS'(r_x + 1'b1);
                    n_scan_addr = AW'(r_scan_addr + 1'b1);
                end
            end

            S_DRAIN: begin
                // Last word read is on the store output now.
                n_peak  = run_max;
                n_state = S_IDLE;
            end

            S_RDWAIT: begin
                n_pix   = ram_rdata;
                n_ch    = '0;
                n_state = S_DIV;
            end

            S_DIV: begin
                if (div_done) begin
                    n_comp[r_ch] = cur_comp;
                    if (r_ch == CH_BITS'(NUM_CHANNELS - 1)) begin
                        n_strobe  = 1'b1;
                        n_in_area = 1'b1;
                        n_packed  = pack_pixel(r_big, n_comp[0], n_comp[1], n_comp[2]);
                        n_state   = S_IDLE;
                    end else begin
                        n_ch = CH_BITS'(r_ch + 1'b1);
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_act_w    <= ACTIVE_RESET;
            r_act_h    <= ACTIVE_RESET;
            r_big      <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_peak     <= '0;
            r_ch       <= '0;
            r_strobe   <= 1'b0;
            r_in_area  <= 1'b0;
            r_packed   <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_act_w    <= n_act_w;
            r_act_h    <= n_act_h;
            r_big      <= n_big;
            r_rd_vld   <= n_rd_vld;
            r_peak     <= n_peak;
            r_ch       <= n_ch;
            r_strobe   <= n_strobe;
            r_in_area  <= n_in_area;
            r_packed   <= n_packed;
        end
        r_x         <= n_x;
        r_y         <= n_y;
        r_scan_addr <= n_scan_addr;
        r_row_base  <= n_row_base;
        r_run       <= n_run;
        r_pix       <= n_pix;
        r_comp      <= n_comp;
    end

    // ------------------------------------------------------------------
    // Instances
    // ------------------------------------------------------------------
    fmnp_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fmnp_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_sample  (div_sample),
        .i_divisor (r_peak),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_packed_pixel = r_packed;
    assign o_in_area      = r_in_area;

`ifndef SYNTHESIS
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start && (i_opcode == OP_READ))))
        else $error("result strobe without a read in flight");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (busy && !o_strobe))
        else $error("activity during the clearing pass");

    a_out_area_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_in_area) |-> (o_packed_pixel == '0))
        else $error("out-of-area read returned a nonzero pixel");

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_in_area) |->
            (r_big ? (o_packed_pixel[COMP_BITS-1:0] == ALPHA_OPAQUE)
                   : (o_packed_pixel[PIXEL_BITS-1 -: COMP_BITS] == ALPHA_OPAQUE)))
        else $error("alpha byte missing from packed pixel");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the read sequence");
`endif

endmodule
